// File: design/cht_pkg.sv
// Shared types and codes for the chained hash table unit.
package cht_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED      = 3'd0,
		ST_UPDATED       = 3'd1,
		ST_FOUND         = 3'd2,
		ST_NOT_FOUND     = 3'd3,
		ST_REMOVED       = 3'd4,
		ST_REMOVE_MISSED = 3'd5,
		ST_BUCKET_FULL   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_WAIT,
		S_CHECK,
		S_DONE
	} state_t;

	localparam int KEY_BITS   = 31;
	localparam int COUNT_BITS = 10;
	localparam int BC_BITS    = 8;

	// Controller to datapath.
	typedef struct packed {
		logic clear;     // one slot of the post-reset clearing pass
		logic load;      // capture input beat, start division
		logic div_step;  // one restoring division step
		logic rd_start;  // start sweep of the bucket ways
		logic rd_step;   // advance way read address
		logic commit;    // apply decision, build result
	} cmd_bus_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;  // last slot being cleared
		logic div_last;
		logic rd_last;   // last way address issued
		logic chk_last;  // last way data arrived
	} stat_bus_t;

endpackage

// File: design/cht_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/cht_ctrl.sv
// Controller state machine of the hash table unit.
module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cht_pkg::cmd_bus_t cmd,
	input  cht_pkg::stat_bus_t stat
);

	cht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			cht_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = cht_pkg::S_IDLE;
				end
			end
			cht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = cht_pkg::S_DIV;
				end
			end
			cht_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = cht_pkg::S_READ;
				end
			end
			cht_pkg::S_READ: begin
				cmd.rd_start = 1'b1;
				state_d      = cht_pkg::S_WAIT;
			end
			cht_pkg::S_WAIT: begin
				cmd.rd_step = 1'b1;
				if (stat.chk_last) begin
					state_d = cht_pkg::S_CHECK;
				end
			end
			cht_pkg::S_CHECK: begin
				cmd.commit = 1'b1;
				state_d    = cht_pkg::S_DONE;
			end
			cht_pkg::S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = cht_pkg::S_IDLE;
				end
			end
			default: state_d = cht_pkg::S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_commit_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("result not presented after commit");
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("ready after load");
`endif

endmodule

// File: design/cht_dp.sv
// Datapath: key modulo divider, way sweep, slot memories and result registers.
module cht_dp #(
	parameter int NUM_BUCKETS = 128,
	parameter int WAYS        = 4,
	parameter int VALUE_BITS  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [cht_pkg::BC_BITS-1:0]       cfg_data,
	input  logic [1:0]                        command,
	input  logic [cht_pkg::KEY_BITS-1:0]      key,
	input  logic [63:0]                       value,
	input  cht_pkg::cmd_bus_t                 cmd,
	output cht_pkg::stat_bus_t                stat,
	output logic [2:0]                        status,
	output logic [63:0]                       value_out,
	output logic [cht_pkg::COUNT_BITS-1:0]    entry_count
);

	localparam int SLOTS  = NUM_BUCKETS * WAYS;
	localparam int SBITS  = $clog2(SLOTS);
	localparam int BBITS  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WBITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int EBITS  = $clog2(NUM_BUCKETS + 1);
	localparam int KB     = cht_pkg::KEY_BITS;
	localparam int CBITS  = $clog2(KB + 1);
	localparam int RBITS  = EBITS + 1;

	logic [cht_pkg::BC_BITS-1:0] bc_q;
	logic [EBITS-1:0]            div_q;
	logic [1:0]                  op_q;
	logic [KB-1:0]               key_q, quo_q;
	logic [VALUE_BITS-1:0]       val_q;
	logic [RBITS-1:0]            rem_q;
	logic [CBITS-1:0]            dcnt_q;
	logic [BBITS-1:0]            bucket_q;
	logic [WBITS-1:0]            raddr_w_q, chk_w_q;
	logic                        chk_en_q;
	logic                        hit_q, free_q;
	logic [WBITS-1:0]            hit_w_q, free_w_q;
	logic [SBITS-1:0]            clr_q;
	logic [cht_pkg::COUNT_BITS-1:0] total_q;

	// bucket_count register; effective divisor clamped to 1..NUM_BUCKETS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= cht_pkg::BC_BITS'(100);
		end else if (cfg_valid) begin
			bc_q <= cfg_data;
		end
	end

	logic [EBITS-1:0] eff;
	always_comb begin
		if (bc_q == '0) begin
			eff = EBITS'(1);
		end else if (32'(bc_q) > NUM_BUCKETS) begin
			eff = EBITS'(NUM_BUCKETS);
		end else begin
			eff = EBITS'(bc_q);
		end
	end

	// restoring division, one quotient bit per cycle, MSB first
	logic [RBITS-1:0] trial;
	assign trial = {rem_q[RBITS-2:0], quo_q[KB-1]};
	assign stat.div_last = (dcnt_q == CBITS'(KB - 1));

	// clearing pass after reset: one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + SBITS'(1);
		end
	end
	assign stat.clr_last = (clr_q == SBITS'(SLOTS - 1));

	// key RAM word is {valid, key}
	logic [KB:0]           rkv;
	logic [KB-1:0]         rk;
	logic [VALUE_BITS-1:0] rv;
	logic [SBITS-1:0]      base_slot, rd_slot, wr_slot;
	logic                  cur_valid;
	assign base_slot = SBITS'(32'(bucket_q) * WAYS);
	assign rd_slot   = base_slot + SBITS'(raddr_w_q);
	assign rk        = rkv[KB-1:0];
	assign cur_valid = rkv[KB];
	assign stat.rd_last  = (raddr_w_q == WBITS'(WAYS - 1));
	assign stat.chk_last = chk_en_q && (chk_w_q == WBITS'(WAYS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= command;
			key_q <= key;
			quo_q <= key;
			val_q <= value[VALUE_BITS-1:0];
			div_q <= eff;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= RBITS'(div_q)) begin
				rem_q <= trial - RBITS'(div_q);
			end else begin
				rem_q <= trial;
			end
			quo_q <= {quo_q[KB-2:0], 1'b0};
		end
		if (stat.div_last && cmd.div_step) begin
			if (trial >= RBITS'(div_q)) begin
				bucket_q <= BBITS'(trial - RBITS'(div_q));
			end else begin
				bucket_q <= BBITS'(trial);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q    <= '0;
			raddr_w_q <= '0;
			chk_w_q   <= '0;
			chk_en_q  <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			hit_w_q   <= '0;
			free_w_q  <= '0;
		end else begin
			if (cmd.load) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + CBITS'(1);
			end
			if (cmd.rd_start) begin
				raddr_w_q <= '0;
				chk_w_q   <= '0;
				chk_en_q  <= 1'b0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
			end else if (cmd.rd_step) begin
				if (!stat.rd_last) begin
					raddr_w_q <= raddr_w_q + WBITS'(1);
				end
				chk_en_q <= 1'b1;
				if (chk_en_q) begin
					chk_w_q <= chk_w_q + WBITS'(1);
					// lowest matching and lowest free way win
					if (cur_valid && rk == key_q && !hit_q) begin
						hit_q   <= 1'b1;
						hit_w_q <= chk_w_q;
					end
					if (!cur_valid && !free_q) begin
						free_q   <= 1'b1;
						free_w_q <= chk_w_q;
					end
				end
			end
		end
	end

	// commit decision
	logic do_ins, do_upd, do_rem;
	always_comb begin
		do_ins = cmd.commit && op_q == cht_pkg::CMD_INSERT && !hit_q && free_q;
		do_upd = cmd.commit && op_q == cht_pkg::CMD_INSERT && hit_q;
		do_rem = cmd.commit && op_q == cht_pkg::CMD_REMOVE && hit_q;
	end

	logic             we_key, we_val;
	logic [SBITS-1:0] kwaddr;
	logic [KB:0]      kwdata;
	assign wr_slot = base_slot + SBITS'(do_ins ? free_w_q : hit_w_q);
	// insert sets the valid bit, remove clears it
	assign we_key  = cmd.clear || do_ins || do_rem;
	assign kwaddr  = cmd.clear ? clr_q : wr_slot;
	assign kwdata  = cmd.clear ? '0 : {do_ins, key_q};
	assign we_val  = do_ins || do_upd;

	// value RAM follows the key RAM address so data of a way streams alongside
	logic [SBITS-1:0] vraddr;
	assign vraddr = rd_slot;

	cht_ram #(.WIDTH(KB + 1), .DEPTH(SLOTS)) u_key_ram (
		.clk(clk), .we(we_key), .waddr(kwaddr), .wdata(kwdata),
		.raddr(rd_slot), .rdata(rkv)
	);
	cht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
		.clk(clk), .we(we_val), .waddr(wr_slot), .wdata(val_q),
		.raddr(vraddr), .rdata(rv)
	);

	// capture value of the matching way while it streams by
	logic [VALUE_BITS-1:0] hv_q;
	always_ff @(posedge clk) begin
		if (cmd.rd_step && chk_en_q && cur_valid && rk == key_q && !hit_q) begin
			hv_q <= rv;
		end
	end

	logic [2:0] st_d;
	always_comb begin
		case (op_q)
			cht_pkg::CMD_INSERT: st_d = hit_q ? cht_pkg::ST_UPDATED :
				(free_q ? cht_pkg::ST_INSERTED : cht_pkg::ST_BUCKET_FULL);
			cht_pkg::CMD_LOOKUP: st_d = hit_q ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
			cht_pkg::CMD_REMOVE: st_d = hit_q ? cht_pkg::ST_REMOVED :
				cht_pkg::ST_REMOVE_MISSED;
			default: st_d = cht_pkg::ST_NOT_FOUND;
		endcase
	end

	logic [cht_pkg::COUNT_BITS-1:0] total_d;
	always_comb begin
		total_d = total_q;
		if (do_ins) begin
			total_d = total_q + cht_pkg::COUNT_BITS'(1);
		end else if (do_rem && total_q != '0) begin
			total_d = total_q - cht_pkg::COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= st_d;
			value_out   <= (op_q == cht_pkg::CMD_LOOKUP && hit_q) ? 64'(hv_q) : '0;
			entry_count <= total_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_start |-> 32'(bucket_q) < NUM_BUCKETS)
		else $error("bucket index out of range");
	a_ins_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |-> free_q && !hit_q)
		else $error("insert without a free way");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(cmd.load || cmd.commit))
		else $error("item activity during clearing pass");
`endif

endmodule

// File: design/chained_hash_table_unit.sv
// Top level of the chained hash table unit.
// Key-value store with bounded separate chaining (WAYS slots per bucket).
// Input channel in_valid/in_ready carries one beat: command, key, value.
// Output channel out_valid/out_ready carries status, value_out, entry_count.
// Config channel cfg_valid/cfg_ready writes bucket_count (always ready);
// write it only while the unit is idle.
// One item at a time: accept, restoring division for key mod
// bucket_count (one bit per cycle), a sweep of the bucket ways through the
// slot RAMs, a commit step, then the result.
// If the receiver stalls the result holds and no new beat is accepted.
// Reset zeroes the pair count and sets bucket_count to 100, then a clearing
// pass over all NUM_BUCKETS * WAYS slots (512 by default) zeroes the slot
// valid bits and keys with in_ready low; values are undefined until written.
module chained_hash_table_unit #(
	parameter int NUM_BUCKETS = 128,
	parameter int WAYS        = 4,
	parameter int VALUE_BITS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [30:0] key,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] value_out,
	output logic [9:0]  entry_count
);

	cht_pkg::cmd_bus_t  cmd;
	cht_pkg::stat_bus_t stat;

	assign cfg_ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);

	cht_dp #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.command(command), .key(key), .value(value),
		.cmd(cmd), .stat(stat),
		.status(status), .value_out(value_out), .entry_count(entry_count)
	);

endmodule

// File: dv/cht_scoreboard.sv
// Checker for the chained hash table unit: table model, prediction and compare.
module cht_scoreboard #(
	parameter int NUM_BUCKETS = 128,
	parameter int WAYS        = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [30:0] key,
	input  logic [63:0] value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [63:0] value_out,
	input  logic [9:0]  entry_count,
	output int          err_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = NUM_BUCKETS * WAYS;

	typedef struct packed {
		cht_pkg::status_t st;
		logic [63:0]      val;
		logic [9:0]       cnt;
	} answer_t;

	logic [7:0]  divisor;
	bit          occupied [SLOTS];
	logic [30:0] tag [SLOTS];
	logic [63:0] word [SLOTS];
	logic [9:0]  pairs;
	answer_t     answers [$];

	assign pending = answers.size();

	function automatic answer_t apply_op(cht_pkg::cmd_t op, logic [30:0] k, logic [63:0] v);
		int      nb, base, hit;
		answer_t a;
		nb = (divisor == 0) ? 1 : ((divisor > NUM_BUCKETS) ? NUM_BUCKETS : divisor);
		base = (k % nb) * WAYS;
		hit = -1;
		a = '{cht_pkg::ST_NOT_FOUND, 64'd0, 10'd0};
		for (int w = 0; w < WAYS; w++)
			if (hit < 0 && occupied[base + w] && tag[base + w] == k)
				hit = base + w;
		case (op)
			cht_pkg::CMD_INSERT: begin
				if (hit >= 0) begin
					word[hit] = v;
					a.st = cht_pkg::ST_UPDATED;
				end else begin
					a.st = cht_pkg::ST_BUCKET_FULL;
					for (int w = 0; w < WAYS; w++)
						if (a.st == cht_pkg::ST_BUCKET_FULL && !occupied[base + w]) begin
							occupied[base + w] = 1;
							tag[base + w] = k;
							word[base + w] = v;
							pairs++;
							a.st = cht_pkg::ST_INSERTED;
						end
				end
			end
			cht_pkg::CMD_LOOKUP: begin
				if (hit >= 0) begin
					a.val = word[hit];
					a.st = cht_pkg::ST_FOUND;
				end
			end
			cht_pkg::CMD_REMOVE: begin
				if (hit >= 0) begin
					occupied[hit] = 0;
					if (pairs > 0) pairs--;
					a.st = cht_pkg::ST_REMOVED;
				end else
					a.st = cht_pkg::ST_REMOVE_MISSED;
			end
			default: ;
		endcase
		a.cnt = pairs;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		if (!arst_n) begin
			divisor <= 8'd100;
			pairs = 0;
			for (int i = 0; i < SLOTS; i++) occupied[i] = 0;
			answers.delete();
			err_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) divisor <= cfg_data;
			if (in_valid && in_ready)
				answers.push_back(apply_op(cht_pkg::cmd_t'(command), key, value));
			if (out_valid && out_ready) begin
				if (answers.size() == 0) begin
					$display("%0t: unexpected result beat status=%0d", $time, status);
					err_count <= err_count + 1;
				end else begin
					exp_a = answers.pop_front();
					if (status !== exp_a.st || value_out !== exp_a.val
							|| entry_count !== exp_a.cnt) begin
						$display("%0t: mismatch exp st=%0d val=%h cnt=%0d got st=%0d val=%h cnt=%0d",
							$time, exp_a.st, exp_a.val, exp_a.cnt, status, value_out, entry_count);
						err_count <= err_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: dv/tb_chained_hash_table_unit.sv
// Testbench top for the chained hash table unit: stimulus and verdict.
module tb_chained_hash_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [7:0]  cfg_data;
	logic        in_valid, in_ready;
	logic [1:0]  command;
	logic [30:0] key;
	logic [63:0] value;
	logic        out_valid, out_ready;
	logic [2:0]  status;
	logic [63:0] value_out;
	logic [9:0]  entry_count;
	int          err_count, pending;
	logic [30:0] recent [16];

	chained_hash_table_unit dut (.*);
	cht_scoreboard chk (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	initial begin
		#200ms;
		$display("status: fail");
		$finish;
	end

	// Receiver stalls: a random hold-off per beat, with quiet stretches.
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			out_ready <= (n == 0);
			if (n != 0) begin
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (!(out_valid && out_ready));
			out_ready <= 1'b0;
		end
	end

	// valid stays up between back-to-back beats; dropped only for idle gaps
	task automatic send_beat(cht_pkg::cmd_t op, logic [30:0] k, logic [63:0] v);
		int n;
		n = $urandom_range(0, 7);
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= op;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_buckets(logic [7:0] n);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Mostly keys from the recent pool or a small range, so updates, hits and full buckets happen.
	function automatic logic [30:0] pick_key(int nb);
		case ($urandom_range(0, 3))
			0: return 31'($urandom);
			1: return recent[$urandom_range(0, 15)];
			default: return 31'($urandom_range(0, nb * 6));
		endcase
	endfunction

	initial begin
		logic [7:0] phase_nb [6];
		int nb;
		cht_pkg::cmd_t op;
		phase_nb = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd7, 8'd100};
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_data = '0;
		in_valid = 1'b0; command = '0; key = '0; value = '0;
		for (int i = 0; i < 16; i++) recent[i] = 31'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset divisor, extremes, full bucket, update, miss, unused command
		send_beat(cht_pkg::CMD_LOOKUP, 31'd5, '0);
		send_beat(cht_pkg::CMD_REMOVE, 31'd5, '0);
		send_beat(cht_pkg::CMD_INSERT, 31'h7fffffff, '1);
		send_beat(cht_pkg::CMD_LOOKUP, 31'h7fffffff, '0);
		send_beat(cht_pkg::CMD_INSERT, 31'd0, '0);
		for (int i = 1; i <= 5; i++) send_beat(cht_pkg::CMD_INSERT, 31'(i * 100), 64'(i));
		send_beat(cht_pkg::CMD_INSERT, 31'd200, 64'hdead_beef_0123_4567);
		send_beat(cht_pkg::CMD_LOOKUP, 31'd200, '0);
		send_beat(cht_pkg::CMD_REMOVE, 31'd200, '0);
		send_beat(cht_pkg::CMD_LOOKUP, 31'd200, '0);
		send_beat(cht_pkg::CMD_INSERT, 31'd500, 64'h5);
		send_beat(cht_pkg::CMD_UNUSED, 31'd100, '1);
		send_beat(cht_pkg::CMD_REMOVE, 31'h7fffffff, '0);
		send_beat(cht_pkg::CMD_LOOKUP, 31'd0, '0);

		for (int p = 0; p < 6; p++) begin
			write_buckets(phase_nb[p]);
			nb = (phase_nb[p] == 0) ? 1 : ((phase_nb[p] > 128) ? 128 : phase_nb[p]);
			for (int i = 0; i < 220; i++) begin
				automatic logic [30:0] k = pick_key(nb);
				recent[$urandom_range(0, 15)] = k;
				case ($urandom_range(0, 19))
					0: op = cht_pkg::CMD_UNUSED;
					1, 2, 3, 4, 5, 6, 7, 8: op = cht_pkg::CMD_INSERT;
					9, 10, 11, 12, 13, 14: op = cht_pkg::CMD_LOOKUP;
					default: op = cht_pkg::CMD_REMOVE;
				endcase
				send_beat(op, k, rand_word());
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
